/* hw/rtl/qrs_pkg.sv */
// Shared widths, solution kinds and pipeline sideband types of the quadratic root solver.
package qrs_pkg;

  // Field and datapath widths.
  localparam int COEF_W     = 16;  // Q8.8 coefficient
  localparam int ROOT_W     = 32;  // Q16.16 root and integer square root
  localparam int D_W        = 35;  // exact discriminant b*b - 4*a*c
  localparam int RAD_W      = 64;  // square root radicand, discriminant times 2^30
  localparam int REM_W      = 36;  // square root partial remainder
  localparam int SQRT_STEPS = 32;  // one root bit per cell
  localparam int NUM0_W     = 33;  // -c*2^16 or -b*2^15
  localparam int NUM_W      = 35;  // numerator with the square root term added
  localparam int MAG_W      = 33;  // numerator and quotient magnitude
  localparam int DIV_STEPS  = 33;  // one quotient bit per cell
  localparam int IN_W       = 48;
  localparam int OUT_W      = 64;
  localparam int USER_W     = 4;

  // Solution kinds as reported on the result word.
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_LINEAR   = 3'd1,
    KIND_DOUBLE   = 3'd2,
    KIND_TWO      = 3'd3,
    KIND_INFINITE = 3'd4
  } kind_t;

  // Sideband that rides along the square root cells.
  typedef struct packed {
    kind_t                     kind;
    logic signed [NUM0_W-1:0]  num0;
    logic signed [COEF_W-1:0]  den;
  } sq_side_t;

  // Sideband that rides along the divider cells.
  typedef struct packed {
    kind_t              kind;
    logic               neg1;
    logic               neg2;
    logic [COEF_W-1:0]  dmag;
  } div_side_t;

endpackage

/* hw/rtl/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front end, square root chain, divider chain, output.
//
// Solves a*x^2 + b*x + c = 0 for Q8.8 coefficients and returns the solution kind with up
// to two Q16.16 roots, truncated toward zero and saturated with an overflow flag. The block
// takes one coefficient word per cycle while the output is not stalled and returns one result word per
// coefficient word, in order. Between the edge that accepts its coefficients and its result word lie
// one input register, one product register, a chain of 32 square root cells (one root bit each), one
// numerator register, a chain of 33 divider cells (one quotient bit each, both roots side by side) and
// the output register. All stages advance together; a stalled output holds the whole chain.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // root_first [31:0], root_second [63:32]
  output logic [USER_W-1:0] m_tuser    // kind [2:0], overflow [3]
);

  logic en;

  // Pipeline moves whenever the output register is empty or being drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input register.
  logic                     v0;
  logic signed [COEF_W-1:0] p0_a, p0_b, p0_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_a <= s_tdata[15:0];
      p0_b <= s_tdata[31:16];
      p0_c <= s_tdata[47:32];
    end
  end

  // Product register: b*b and a*c.
  logic                     v1;
  logic signed [COEF_W-1:0] p1_a, p1_b, p1_c;
  logic signed [2*COEF_W-1:0] p1_bb, p1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_a  <= p0_a;
      p1_b  <= p0_b;
      p1_c  <= p0_c;
      p1_bb <= p0_b * p0_b;
      p1_ac <= p0_a * p0_c;
    end
  end

  // Discriminant, classification and the front of the square root chain.
  logic                     sq_vld  [0:SQRT_STEPS];
  sq_side_t                 sq_side [0:SQRT_STEPS];
  logic [RAD_W-1:0]         sq_rad  [0:SQRT_STEPS];
  logic [REM_W-1:0]         sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0]        sq_root [0:SQRT_STEPS];
  logic signed [D_W-1:0]    disc;
  kind_t                    kind0;

  always_comb begin
    disc = D_W'(p1_bb) - (D_W'(p1_ac) <<< 2);
    if (p1_a == '0) begin
      if (p1_b == '0) begin
        kind0 = (p1_c == '0) ? KIND_INFINITE : KIND_NONE;
      end else begin
        kind0 = KIND_LINEAR;
      end
    end else if (disc < 0) begin
      kind0 = KIND_NONE;
    end else if (disc == '0) begin
      kind0 = KIND_DOUBLE;
    end else begin
      kind0 = KIND_TWO;
    end

    sq_vld[0]       = v1;
    sq_side[0].kind = kind0;
    if (p1_a == '0) begin
      sq_side[0].num0 = NUM0_W'(0) - (NUM0_W'(p1_c) <<< 16);
      sq_side[0].den  = p1_b;
    end else begin
      sq_side[0].num0 = NUM0_W'(0) - (NUM0_W'(p1_b) <<< 15);
      sq_side[0].den  = p1_a;
    end
    sq_rad[0]  = (kind0 == KIND_TWO) ? {disc[RAD_W-31:0], 30'b0} : '0;
    sq_rem[0]  = '0;
    sq_root[0] = '0;
  end

  // Square root chain.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (sq_vld[i]),
      .in_side  (sq_side[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .out_vld  (sq_vld[i+1]),
      .out_side (sq_side[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1])
    );
  end

  // Numerators (-c*2^16 or -b*2^15, plus or minus the root), split into sign and magnitude.
  sq_side_t              nm_side;
  logic signed [NUM_W-1:0] n1, n2;
  logic [NUM_W-1:0]      n1_abs, n2_abs;
  logic [COEF_W-1:0]     dmag;

  always_comb begin
    nm_side = sq_side[SQRT_STEPS];
    n1 = NUM_W'(nm_side.num0);
    if (nm_side.kind == KIND_TWO) begin
      n1 = NUM_W'(nm_side.num0) + $signed(NUM_W'(sq_root[SQRT_STEPS]));
    end
    n2     = NUM_W'(nm_side.num0) - $signed(NUM_W'(sq_root[SQRT_STEPS]));
    n1_abs = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    n2_abs = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    dmag   = nm_side.den[COEF_W-1] ? COEF_W'(-nm_side.den) : COEF_W'(nm_side.den);
  end

  logic               dv_vld  [0:DIV_STEPS];
  div_side_t          dv_side [0:DIV_STEPS];
  logic [MAG_W-1:0]   dv_q1   [0:DIV_STEPS];
  logic [MAG_W-1:0]   dv_q2   [0:DIV_STEPS];
  logic [COEF_W-1:0]  dv_r1   [0:DIV_STEPS];
  logic [COEF_W-1:0]  dv_r2   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0].kind <= nm_side.kind;
      dv_side[0].neg1 <= n1[NUM_W-1] ^ nm_side.den[COEF_W-1];
      dv_side[0].neg2 <= n2[NUM_W-1] ^ nm_side.den[COEF_W-1];
      dv_side[0].dmag <= dmag;
      dv_q1[0]        <= n1_abs[MAG_W-1:0];
      dv_q2[0]        <= n2_abs[MAG_W-1:0];
      dv_r1[0]        <= '0;
      dv_r2[0]        <= '0;
    end
  end

  // Divider chain.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_vld   (dv_vld[j]),
      .in_side  (dv_side[j]),
      .in_q1    (dv_q1[j]),
      .in_q2    (dv_q2[j]),
      .in_r1    (dv_r1[j]),
      .in_r2    (dv_r2[j]),
      .out_vld  (dv_vld[j+1]),
      .out_side (dv_side[j+1]),
      .out_q1   (dv_q1[j+1]),
      .out_q2   (dv_q2[j+1]),
      .out_r1   (dv_r1[j+1]),
      .out_r2   (dv_r2[j+1])
    );
  end

  // Apply the sign and saturate to Q16.16; the top bit is the overflow flag.
  function automatic logic [ROOT_W:0] clamp_root(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] lim;
    lim = {{(MAG_W-ROOT_W){1'b0}}, 1'b1, {(ROOT_W-1){1'b0}}};
    if (!neg && mag >= lim) begin
      return {1'b1, 1'b0, {(ROOT_W-1){1'b1}}};
    end else if (neg && mag > lim) begin
      return {1'b1, 1'b1, {(ROOT_W-1){1'b0}}};
    end else if (neg) begin
      return {1'b0, ROOT_W'(-mag[ROOT_W-1:0])};
    end else begin
      return {1'b0, mag[ROOT_W-1:0]};
    end
  endfunction

  div_side_t         fin_side;
  logic [ROOT_W:0]   c1, c2;
  logic [ROOT_W-1:0] r1_next, r2_next;
  logic              ovf_next;

  always_comb begin
    fin_side = dv_side[DIV_STEPS];
    c1       = clamp_root(fin_side.neg1, dv_q1[DIV_STEPS]);
    c2       = clamp_root(fin_side.neg2, dv_q2[DIV_STEPS]);
    r1_next  = '0;
    r2_next  = '0;
    ovf_next = 1'b0;
    case (fin_side.kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        r1_next  = c1[ROOT_W-1:0];
        ovf_next = c1[ROOT_W];
      end
      KIND_TWO: begin
        r1_next  = c1[ROOT_W-1:0];
        r2_next  = c2[ROOT_W-1:0];
        ovf_next = c1[ROOT_W] | c2[ROOT_W];
      end
      default: begin
        r1_next  = '0;
        r2_next  = '0;
        ovf_next = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {r2_next, r1_next};
      m_tuser <= {ovf_next, fin_side.kind};
    end
  end

endmodule

/* hw/rtl/qrs_sqrt_cell.sv */
// One step of the digit-by-digit integer square root: resolves one root bit per cycle while enabled.
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  sq_side_t          in_side,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_vld,
  output sq_side_t          out_side,
  output logic [RAD_W-1:0]  out_rad,
  output logic [REM_W-1:0]  out_rem,
  output logic [ROOT_W-1:0] out_root
);

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [ROOT_W-1:0] root_next;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    shifted   = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
    trial     = {{(REM_W-ROOT_W-2){1'b0}}, in_root, 2'b01};
    ge        = (shifted >= trial);
    rem_next  = ge ? (shifted - trial) : shifted;
    root_next = {in_root[ROOT_W-2:0], ge};
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
      out_rem  <= rem_next;
      out_root <= root_next;
    end
  end

endmodule

/* hw/rtl/qrs_div_cell.sv */
// One restoring division step for both root lanes: resolves one quotient bit per cycle while enabled.
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  div_side_t         in_side,
  input  logic [MAG_W-1:0]  in_q1,
  input  logic [MAG_W-1:0]  in_q2,
  input  logic [COEF_W-1:0] in_r1,
  input  logic [COEF_W-1:0] in_r2,
  output logic              out_vld,
  output div_side_t         out_side,
  output logic [MAG_W-1:0]  out_q1,
  output logic [MAG_W-1:0]  out_q2,
  output logic [COEF_W-1:0] out_r1,
  output logic [COEF_W-1:0] out_r2
);

  // The numerator leaves at the top of q while quotient bits enter at the bottom.
  function automatic logic [MAG_W+COEF_W-1:0] div_step(
    input logic [MAG_W-1:0]  q,
    input logic [COEF_W-1:0] r,
    input logic [COEF_W-1:0] d
  );
    logic [COEF_W:0]   t;
    logic              ge;
    logic [COEF_W-1:0] r_n;
    t   = {r, q[MAG_W-1]};
    ge  = (t >= {1'b0, d});
    r_n = ge ? COEF_W'(t - {1'b0, d}) : t[COEF_W-1:0];
    return {q[MAG_W-2:0], ge, r_n};
  endfunction

  logic [MAG_W+COEF_W-1:0] step1;
  logic [MAG_W+COEF_W-1:0] step2;

  always_comb begin
    step1 = div_step(in_q1, in_r1, in_side.dmag);
    step2 = div_step(in_q2, in_r2, in_side.dmag);
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_q1   <= step1[MAG_W+COEF_W-1:COEF_W];
      out_r1   <= step1[COEF_W-1:0];
      out_q2   <= step2[MAG_W+COEF_W-1:COEF_W];
      out_r2   <= step2[COEF_W-1:0];
    end
  end

endmodule

/* hw/rtl/qrs_checker.sv */
// Port-level checks for the quadratic root solver and the bind that attaches them.
module qrs_checker
  import qrs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic [USER_W-1:0] m_tuser
);

  // A stalled result word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // No result right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Kinds without roots report zero roots and no overflow.
  a_noroot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_NONE || m_tuser[2:0] == KIND_INFINITE)
    |-> m_tdata == '0 && !m_tuser[3])
    else $error("roots reported for a kind without roots");

  // Single-root kinds leave the second root at zero.
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] == KIND_LINEAR || m_tuser[2:0] == KIND_DOUBLE)
    |-> m_tdata[63:32] == '0)
    else $error("second root set for a single root");

  // Ready to take input exactly when the output can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output flow");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
